[rtl/assert_macros.svh]
// assertion macros used by the filter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define KFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kfr assertion failed");

// condition that must never hold outside reset
`define KFR_ASSERT_NEVER(lbl, cond) \
  `KFR_ASSERT(lbl, !(cond))

`endif

[rtl/kfr_pkg.sv]
// types, constants and helpers of the kuwahara filter
package kfr_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int LS_AW     = $clog2(MAX_WIDTH);
  localparam int WMAX_INT  = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

  localparam logic [11:0] WIDTH_MAX   = 12'(WMAX_INT);
  localparam logic [11:0] HEIGHT_MAX  = 12'd2048;
  localparam logic [11:0] SIZE_MIN    = 12'd5;
  localparam logic [11:0] WIDTH_RST   = 12'd640;
  localparam logic [11:0] HEIGHT_RST  = 12'd480;

  // register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  // reciprocal of nine, exact for inputs below 2^21
  localparam logic [17:0] DIV9_MUL   = 18'd233017;
  localparam int          DIV9_SHIFT = 21;

  // one pixel, index 2 red, 1 green, 0 blue
  typedef logic [2:0][7:0] pix_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [10:0] out_col;
    logic [10:0] out_row;
    logic        frame_last;
  } out_t;

  // position data that travels with a pixel
  typedef struct packed {
    logic [10:0] col;
    logic [10:0] row;
    logic        last;
  } meta_t;

  // floor(x / 9) by multiply and shift
  function automatic logic [16:0] div9(input logic [19:0] x);
    logic [37:0] p;
    p = x * DIV9_MUL;
    return p[37:DIV9_SHIFT];
  endfunction

endpackage

[rtl/kfr_line_store.sv]
// four banked line stores with registered read
module kfr_line_store
  import kfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [LS_AW-1:0] addr_i,
  input  logic [1:0]       wr_bank_i,
  input  pix_t             wr_data_i,
  output pix_t [3:0]       rd_data_o
);

  pix_t mem_q [4][MAX_WIDTH];
  pix_t [3:0] rd_q;

  // read all banks at the column, write the current row's bank
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int b = 0; b < 4; b++) begin
        rd_q[b] <= mem_q[b][addr_i];
        if (wr_bank_i == 2'(b)) begin
          mem_q[b][addr_i] <= wr_data_i;
        end
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

[rtl/kuwahara_filter_rgb_unit.sv]
// top level of the rgb kuwahara filter, 5x5 window with four 3x3 quadrants
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------
//  in      | in_valid_i/in_ready_o | in_data_i   (in_t)
//  out     | out_valid_o/out_ready_i | out_data_o (out_t)
//  cfg     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// one pixel per cycle while in_ready_o is high; a result passes stage 1 beside the line store
// read, then the window, squares and sums, divide by nine, least-variance pick and out register
// reset clears counters, window and stage valids; registers go to 640x480
// the stages collapse bubbles, so a stalled output only blocks input
// once every stage holds a transaction
module kuwahara_filter_rgb_unit
  import kfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

`include "assert_macros.svh"

  logic [11:0] width_q, height_q, w_use, h_use;
  logic [10:0] col_q, row_q, col_d, row_d;
  logic        accept;
  pix_t        pix_in;
  pix_t [3:0]  ls_rd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp sizes in use
  always_comb begin
    if (width_q < SIZE_MIN) w_use = SIZE_MIN;
    else if (width_q > WIDTH_MAX) w_use = WIDTH_MAX;
    else w_use = width_q;
    if (height_q < SIZE_MIN) h_use = SIZE_MIN;
    else if (height_q > HEIGHT_MAX) h_use = HEIGHT_MAX;
    else h_use = height_q;
  end

  assign accept = in_valid_i && in_ready_o;
  assign pix_in = {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};

  // raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if ({1'b0, col_q} + 12'd1 >= w_use) begin
      col_d = '0;
      row_d = ({1'b0, row_q} + 12'd1 >= h_use) ? '0 : row_q + 11'd1;
    end else begin
      col_d = col_q + 11'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  kfr_line_store u_line_store (
    .clk_i     (clk_i),
    .en_i      (accept),
    .addr_i    (LS_AW'(col_q)),
    .wr_bank_i (row_q[1:0]),
    .wr_data_i (pix_in),
    .rd_data_o (ls_rd)
  );

  // stage valids and advance terms
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = v5_q && (!out_valid_q || out_ready_i);
  assign adv4 = v4_q && (!v5_q || adv5);
  assign adv3 = v3_q && (!v4_q || adv4);
  assign adv2 = v2_q && (!v3_q || adv3);
  assign adv1 = v1_q && (!v2_q || adv2);
  assign in_ready_o = !v1_q || adv1;

  // stage 1: pixel and position beside the line store read
  pix_t  pix1_q;
  logic  emit1_q;
  logic [1:0] bank1_q;
  meta_t meta1_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q       <= pix_in;
      bank1_q      <= row_q[1:0];
      emit1_q      <= (col_q >= 11'd4) && (row_q >= 11'd4) &&
                      ({1'b0, col_q} < w_use) && ({1'b0, row_q} < h_use);
      meta1_q.col  <= col_q - 11'd2;
      meta1_q.row  <= row_q - 11'd2;
      meta1_q.last <= ({1'b0, col_q} == w_use - 12'd1) &&
                      ({1'b0, row_q} == h_use - 12'd1);
    end
  end

  // stage 2: the 5x5 window
  pix_t  win_q [5][5];
  meta_t meta2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) begin
        for (int l = 0; l < 5; l++) begin
          win_q[k][l] <= '0;
        end
      end
    end else if (adv1) begin
      for (int k = 0; k < 5; k++) begin
        for (int l = 0; l < 4; l++) begin
          win_q[k][l] <= win_q[k][l+1];
        end
      end
      for (int k = 0; k < 4; k++) begin
        win_q[k][4] <= ls_rd[2'(bank1_q + 2'(k))];
      end
      win_q[4][4] <= pix1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) meta2_q <= meta1_q;
  end

  // squares of every cell and quadrant sums
  logic [15:0] sq3_d [3][5][5];
  logic [11:0] sum3_d [3][4];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 5; k++) begin
        for (int l = 0; l < 5; l++) begin
          sq3_d[ch][k][l] = 16'(win_q[k][l][ch]) * 16'(win_q[k][l][ch]);
        end
      end
      for (int q = 0; q < 4; q++) begin
        sum3_d[ch][q] = '0;
        for (int k = 0; k < 3; k++) begin
          for (int l = 0; l < 3; l++) begin
            sum3_d[ch][q] = sum3_d[ch][q] +
                            12'(win_q[(q % 2) * 2 + k][(q / 2) * 2 + l][ch]);
          end
        end
      end
    end
  end

  // stage 3: registered squares and sums
  logic [15:0] sq3_q [3][5][5];
  logic [11:0] sum3_q [3][4];
  meta_t       meta3_q;
  logic [19:0] ssq4_d [3][4];

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      sq3_q   <= sq3_d;
      sum3_q  <= sum3_d;
      meta3_q <= meta2_q;
    end
  end

  // quadrant sums of squares
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int q = 0; q < 4; q++) begin
        ssq4_d[ch][q] = '0;
        for (int k = 0; k < 3; k++) begin
          for (int l = 0; l < 3; l++) begin
            ssq4_d[ch][q] = ssq4_d[ch][q] +
                            20'(sq3_q[ch][(q % 2) * 2 + k][(q / 2) * 2 + l]);
          end
        end
      end
    end
  end

  // stage 4: divide by nine
  logic [11:0] sum4_q [3][4];
  logic [19:0] ssq4_q [3][4];
  meta_t       meta4_q;
  logic [16:0] mean5_d [3][4];
  logic [16:0] sq9_5_d [3][4];

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      sum4_q  <= sum3_q;
      ssq4_q  <= ssq4_d;
      meta4_q <= meta3_q;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int q = 0; q < 4; q++) begin
        mean5_d[ch][q] = div9({8'd0, sum4_q[ch][q]});
        sq9_5_d[ch][q] = div9(ssq4_q[ch][q]);
      end
    end
  end

  // stage 5: variance and least-variance pick
  logic [7:0]  mean5_q [3][4];
  logic [16:0] sq9_5_q [3][4];
  meta_t       meta5_q;
  logic [16:0] var_v, best_var;
  logic [7:0]  best_mean [3];
  out_t        out_d, out_q;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int q = 0; q < 4; q++) begin
          mean5_q[ch][q] <= mean5_d[ch][q][7:0];
        end
      end
      sq9_5_q <= sq9_5_d;
      meta5_q <= meta4_q;
    end
  end

  // strict less keeps the earlier quadrant on a tie
  always_comb begin
    best_var = '0;
    var_v    = '0;
    for (int ch = 0; ch < 3; ch++) begin
      best_mean[ch] = mean5_q[ch][0];
      best_var      = sq9_5_q[ch][0] - 17'(16'(mean5_q[ch][0]) * 16'(mean5_q[ch][0]));
      for (int q = 1; q < 4; q++) begin
        var_v = sq9_5_q[ch][q] - 17'(16'(mean5_q[ch][q]) * 16'(mean5_q[ch][q]));
        if (var_v < best_var) begin
          best_var      = var_v;
          best_mean[ch] = mean5_q[ch][q];
        end
      end
    end
    out_d.out_red    = best_mean[2];
    out_d.out_green  = best_mean[1];
    out_d.out_blue   = best_mean[0];
    out_d.out_col    = meta5_q.col;
    out_d.out_row    = meta5_q.row;
    out_d.frame_last = meta5_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (adv5) out_q <= out_d;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) v1_q <= 1'b1;
      else if (adv1) v1_q <= 1'b0;
      if (adv1) v2_q <= emit1_q;
      else if (adv2) v2_q <= 1'b0;
      if (adv2) v3_q <= 1'b1;
      else if (adv3) v3_q <= 1'b0;
      if (adv3) v4_q <= 1'b1;
      else if (adv4) v4_q <= 1'b0;
      if (adv4) v5_q <= 1'b1;
      else if (adv5) v5_q <= 1'b0;
      if (adv5) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an accepted transaction always lands in stage one
  `KFR_ASSERT(acc_fills_s1, accept |=> v1_q)
  // a blocked stage one keeps its transaction
  `KFR_ASSERT(s1_holds, (v1_q && !adv1) |=> v1_q)
  // filtered pixels stay off the two-deep top and left border
  `KFR_ASSERT_NEVER(out_on_border, out_valid_o && (out_data_o.out_col < 11'd2 || out_data_o.out_row < 11'd2))

endmodule

[tb/tb.sv]
// testbench for the rgb kuwahara filter, scoreboard and stimulus
module tb;
  import kfr_pkg::*;

  // predicts filtered pixels and checks them in order
  class kuwahara_scoreboard;
    logic [23:0] line_mem[4*MAX_WIDTH];
    logic [23:0] win[5][5];
    int unsigned col, row, width_reg, height_reg;
    out_t pending[$];
    int errors;
    int results;

    function void reset_state();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col = 0;
      row = 0;
      width_reg = 640;
      height_reg = 480;
      pending.delete();
      errors = 0;
      results = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] val);
      if (idx == CFG_WIDTH) width_reg = val;
      else if (idx == CFG_HEIGHT) height_reg = val;
    endfunction

    // least-variance quadrant mean for one channel
    function logic [7:0] quad_mean(int sh);
      int unsigned best_var, best_mean, s, sq, v, m, var_q;
      best_var = 0;
      best_mean = 0;
      for (int qx = 0; qx < 2; qx++) begin
        for (int qy = 0; qy < 2; qy++) begin
          s = 0;
          sq = 0;
          for (int k = 0; k < 3; k++) begin
            for (int l = 0; l < 3; l++) begin
              v = (win[qy*2+k][qx*2+l] >> sh) & 8'hff;
              s += v;
              sq += v * v;
            end
          end
          m = s / 9;
          var_q = sq / 9 - m * m;
          if ((qx == 0 && qy == 0) || var_q < best_var) begin
            best_var = var_q;
            best_mean = m;
          end
        end
      end
      return best_mean[7:0];
    endfunction

    // one accepted pixel transaction
    function void note_pixel(in_t p);
      int unsigned w, h, cidx;
      logic [23:0] pix;
      out_t e;
      w = width_reg < 5 ? 5 : (width_reg > WMAX_INT ? WMAX_INT : width_reg);
      h = height_reg < 5 ? 5 : (height_reg > 2048 ? 2048 : height_reg);
      pix = {p.in_red, p.in_green, p.in_blue};
      cidx = col % MAX_WIDTH;
      for (int k = 0; k < 5; k++)
        for (int l = 0; l < 4; l++) win[k][l] = win[k][l+1];
      for (int k = 0; k < 4; k++) win[k][4] = line_mem[((row + k) & 3) * MAX_WIDTH + cidx];
      win[4][4] = pix;
      line_mem[(row & 3) * MAX_WIDTH + cidx] = pix;
      if (col >= 4 && row >= 4 && col < w && row < h) begin
        e.out_red = quad_mean(16);
        e.out_green = quad_mean(8);
        e.out_blue = quad_mean(0);
        e.out_col = 11'(col - 2);
        e.out_row = 11'(row - 2);
        e.frame_last = (col == w - 1 && row == h - 1);
        pending.push_back(e);
      end
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    // one accepted result transaction
    function void check_result(out_t a);
      out_t e;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.out_red !== e.out_red)
        $display("%0t: out_red exp %0d got %0d", $time, e.out_red, a.out_red);
      if (a.out_green !== e.out_green)
        $display("%0t: out_green exp %0d got %0d", $time, e.out_green, a.out_green);
      if (a.out_blue !== e.out_blue)
        $display("%0t: out_blue exp %0d got %0d", $time, e.out_blue, a.out_blue);
      if (a.out_col !== e.out_col)
        $display("%0t: out_col exp %0d got %0d", $time, e.out_col, a.out_col);
      if (a.out_row !== e.out_row)
        $display("%0t: out_row exp %0d got %0d", $time, e.out_row, a.out_row);
      if (a.frame_last !== e.frame_last)
        $display("%0t: frame_last exp %0d got %0d", $time, e.frame_last, a.frame_last);
      if (a !== e) errors++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_WIDTH;
  logic [11:0] cfg_data_i = '0;

  kuwahara_filter_rgb_unit uut (.*);

  kuwahara_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned random_pixels = 0;
  bit          hold_req = 1'b0;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 1500000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned seg;
    seg = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int unsigned n = 0; n < 300; n++) begin
          out_ready_i = 1'b0;
          @(negedge clk_i);
        end
      end
      if (seg == 0) begin
        seg = $urandom_range(50, 400);
        mode = $urandom_range(0, 3);
      end
      seg--;
      case (mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = ($urandom_range(0, 3) != 0);
        2: out_ready_i = ($urandom_range(0, 1) != 0);
        default: out_ready_i = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [11:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // one pixel transaction, with random bursts and gaps on the input side
  task automatic send_pixel(in_t p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = p;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(p);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [7:0] chan_value(int unsigned mode, logic [7:0] base);
    case (mode)
      0: return 8'($urandom);
      1: return base;
      2: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: return 8'(base + $urandom_range(0, 6));
    endcase
  endfunction

  // one whole frame of pixels, content style picked per frame and re-picked at random within it
  task automatic send_frame(int unsigned w, int unsigned h, bit count_it);
    int unsigned mode;
    logic [7:0] base;
    in_t p;
    mode = $urandom_range(0, 3);
    base = 8'($urandom);
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 3);
      p.in_red = chan_value(mode, base);
      p.in_green = chan_value(mode, base);
      p.in_blue = chan_value(mode, base);
      send_pixel(p);
      if (count_it) random_pixels++;
    end
  endtask

  initial begin
    in_t p;
    int unsigned w, h;
    sb.reset_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // out-of-range sizes clamp up to a 5x5 frame; directed corner pixels
    write_cfg(CFG_WIDTH, 12'd3);
    write_cfg(CFG_HEIGHT, 12'd4);
    for (int i = 0; i < 25; i++) begin
      case (i % 5)
        0: p = '0;
        1: p = '1;
        2: p = {8'hff, 8'h00, 8'hff};
        3: p = {8'h00, 8'hff, 8'h00};
        default: p = {8'd9, 8'd9, 8'd9};
      endcase
      if (i >= 20) p = in_t'($urandom);
      send_pixel(p);
    end
    wait_drained();

    // long receiver hold-off while a full frame is offered
    write_cfg(CFG_WIDTH, 12'd16);
    write_cfg(CFG_HEIGHT, 12'd10);
    hold_req = 1'b1;
    send_frame(16, 10, 1'b1);
    wait_drained();

    // random small frames
    while (random_pixels < 1850) begin
      w = $urandom_range(5, 16);
      h = $urandom_range(5, 10);
      write_cfg(CFG_WIDTH, ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 4)) : 12'(w));
      if (sb.width_reg < 5) w = 5;
      write_cfg(CFG_HEIGHT, 12'(h));
      send_frame(w, h, 1'b1);
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
